@@ hdl/m2h_pkg.sv @@
// shared constants, command type and sequencer states for the murmur2 hash stream
package m2h_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // one unit of work for the back end, applied as load, then mix, then finish
   typedef struct packed {
      logic        load;
      logic        mix;
      logic        fin;
      logic        tail_nz;
      logic [31:0] data;
      logic [23:0] tail;
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MIX1 = 6'b000010,
      ST_MIX2 = 6'b000100,
      ST_MIX3 = 6'b001000,
      ST_FIN1 = 6'b010000,
      ST_FIN2 = 6'b100000
   } state_type;

endpackage

@@ hdl/m2h_front.sv @@
// byte gathering, seed register and command classification
module m2h_front
   import m2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  data_byte,
   input  logic        first,
   input  logic        last,
   input  logic [31:0] total_length,
   output logic        push,
   output cmd_type     push_cmd,
   input  logic        queue_full
);

   logic [31:0] seed_ff;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  count_ff, count_in;
   logic [23:0] gather_cur;
   logic [1:0]  count_cur;
   logic        accept;
   cmd_type     cmd;

   assign csr_ready  = 1'b1;
   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & ~queue_full;

   always_comb begin
      gather_cur = first ? 24'd0 : gather_ff;
      count_cur  = first ? 2'd0 : count_ff;
      gather_in  = gather_cur;
      count_in   = count_cur;
      cmd        = '0;
      cmd.load   = first;
      cmd.data   = seed_ff ^ total_length;
      if (first && total_length == 32'd0) begin
         cmd.fin   = 1'b1;
         gather_in = 24'd0;
         count_in  = 2'd0;
      end else begin
         case (count_cur)
            2'd0: begin
               gather_in[7:0] = data_byte;
               count_in       = 2'd1;
            end
            2'd1: begin
               gather_in[15:8] = data_byte;
               count_in        = 2'd2;
            end
            2'd2: begin
               gather_in[23:16] = data_byte;
               count_in         = 2'd3;
            end
            default: begin
               cmd.mix   = 1'b1;
               cmd.data  = {data_byte, gather_cur};
               gather_in = 24'd0;
               count_in  = 2'd0;
            end
         endcase
         if (last) begin
            cmd.fin     = 1'b1;
            cmd.tail_nz = (count_in != 2'd0);
            cmd.tail    = gather_in;
            gather_in   = 24'd0;
            count_in    = 2'd0;
         end
      end
   end

   assign push     = accept & (cmd.load | cmd.mix | cmd.fin);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= 32'd0;
         gather_ff <= 24'd0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
         if (accept) begin
            gather_ff <= gather_in;
            count_ff  <= count_in;
         end
      end
   end

endmodule

@@ hdl/m2h_queue.sv @@
// small command queue between front and back
module m2h_queue
   import m2h_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full      = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

@@ hdl/m2h_back.sv @@
// mixing sequencer with one shared multiplier and the result register
module m2h_back
   import m2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata
);

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [31:0] mul_a, prod, fin_hash;

   always_comb begin
      case (state_ff)
         ST_MIX1: mul_a = cmd_ff.data;
         ST_MIX2: mul_a = k_ff ^ (k_ff >> MIX_SHIFT);
         ST_MIX3: mul_a = h_ff;
         ST_FIN1: mul_a = h_ff ^ {8'd0, cmd_ff.tail};
         ST_FIN2: mul_a = h_ff ^ (h_ff >> FIN_SHIFT_A);
         default: mul_a = h_ff;
      endcase
   end

   assign prod     = mul_a * MIX_MUL;
   assign fin_hash = prod ^ (prod >> FIN_SHIFT_B);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.load) begin
                  h_in = cmd.data;
               end
               if (cmd.mix) begin
                  state_in = ST_MIX1;
               end else if (cmd.fin) begin
                  state_in = ST_FIN1;
               end
            end
         end
         ST_MIX1: begin
            k_in     = prod;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            k_in     = prod;
            state_in = ST_MIX3;
         end
         ST_MIX3: begin
            h_in     = prod ^ k_ff;
            state_in = cmd_ff.fin ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            if (cmd_ff.tail_nz) begin
               h_in = prod;
            end
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (!rsp_valid_ff || rsp_tready) begin
               h_in         = fin_hash;
               rsp_valid_in = 1'b1;
               rsp_data_in  = fin_hash;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/murmur2_hash_stream.sv @@
// top level of the streaming murmur2 32-bit hash
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   tdata: data_byte, total_length; tuser: first;
//                                              tlast: last
//  rsp      out        rsp_tvalid/rsp_tready   tdata: hash_value
//  csr      in         csr_valid/csr_ready     csr_data: seed
//
// bytes are taken one a cycle while the command queue has room
// a word takes a queue pop and three passes through the one shared 32x32 multiplier
// (MIX1-MIX3), a finish adds FIN1 and FIN2 (after its own pop if alone), a bare first a pop
// long messages keep close to one byte a cycle, a one-byte message a pop, FIN1 and FIN2
// reset clears the seed, the running hash, the byte gather, the queue and the result valid
// a stalled result holds the back end in its last step and the front fills the queue
module murmur2_hash_stream
   import m2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte [7:0], total_length [39:8]
   input  logic        req_tuser,   // first
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // hash_value [31:0]
);

   logic    push, queue_full, pop, pop_valid;
   cmd_type push_cmd, pop_cmd;

   m2h_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .data_byte    (req_tdata[7:0]),
      .first        (req_tuser),
      .last         (req_tlast),
      .total_length (req_tdata[39:8]),
      .push         (push),
      .push_cmd     (push_cmd),
      .queue_full   (queue_full)
   );

   m2h_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   m2h_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
